// ===== rtl/maf_pkg.sv =====
// shared widths, constants and types for the magnet angle block
`default_nettype none

package maf_pkg;

   localparam int BYTE_W    = 8;
   localparam int NIBBLE_W  = 4;
   localparam int FIELD_W   = 12;
   localparam int ANGLE_W   = 9;
   localparam int ACC_W     = 11;
   localparam int OCT_W     = 7;
   localparam int QUO_W     = 10;
   localparam int REM_W     = 13;
   localparam int NUM_W     = 21;
   localparam int SCALED_W  = 16;
   localparam int STEP_W    = 4;

   localparam int RATIO_SCALE    = 1000;
   localparam int OCTANT_DEG     = 45;
   localparam int ROUND_BIAS     = 500;
   localparam int RIGHT_ANGLE    = 90;
   localparam int STRAIGHT_ANGLE = 180;
   localparam int FULL_ANGLE     = 360;

   // quotient bits produced by each division pass
   localparam int RATIO_STEPS = QUO_W;
   localparam int SCALE_STEPS = 6;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_PREP      = 5'b00010,
      ST_DIV_RATIO = 5'b00100,
      ST_DIV_SCALE = 5'b01000,
      ST_FINISH    = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/maf_if.sv =====
// request and response channel interfaces
`default_nettype none

interface maf_req_if import maf_pkg::*;;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  x_high_byte;
   logic [BYTE_W-1:0]  y_high_byte;
   logic [BYTE_W-1:0]  low_nibbles_byte;
   logic               read_ok;

   modport source (output valid, x_high_byte, y_high_byte, low_nibbles_byte, read_ok,
                   input ready);
   modport sink   (input valid, x_high_byte, y_high_byte, low_nibbles_byte, read_ok,
                   output ready);
endinterface

interface maf_rsp_if import maf_pkg::*;;
   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] angle_deg;
   logic [ANGLE_W-1:0] filtered_angle;
   logic               read_error;

   modport source (output valid, angle_deg, filtered_angle, read_error, input ready);
   modport sink   (input valid, angle_deg, filtered_angle, read_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/maf_serial_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module maf_serial_div import maf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire div_ctl_type        ctl,
   input  wire logic [REM_W-1:0]   rem_init,
   input  wire logic [QUO_W-1:0]   low_init,
   input  wire logic [FIELD_W-1:0] divisor,
   output div_sts_type             sts,
   output logic [QUO_W-1:0]        quotient
);

   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   low_ff, low_in;
   logic [FIELD_W-1:0] div_ff, div_in;
   logic [STEP_W-1:0]  count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [REM_W-1:0]   shifted;
   logic               fits;

   // remainder stays below the divisor, so its top bit is free for the shift
   assign shifted = {rem_ff[REM_W-2:0], low_ff[QUO_W-1]};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      rem_in   = rem_ff;
      low_in   = low_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         rem_in   = rem_init;
         low_in   = low_init;
         div_in   = divisor;
         count_in = ctl.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? (shifted - {1'b0, div_ff}) : shifted;
         low_in   = {low_ff[QUO_W-2:0], fits};
         count_in = count_ff - STEP_W'(1);
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      div_ff <= div_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = low_ff;

endmodule

`default_nettype wire

// ===== rtl/magnet_angle_from_xy_field.sv =====
// top level: coarse atan2 of an xy field readout with an averaged angle
//
//   channel  dir  handshake          payload
//   req_ch   in   valid / ready      x_high_byte, y_high_byte, low_nibbles_byte, read_ok
//   rsp_ch   out  valid / ready      angle_deg, filtered_angle, read_error
//
// one request at a time; a good readout passes through prep, the serial divider and a
// finish step: 10 quotient bits for the octant ratio, then 6 for the degree scaling, with
// a hand-over step between the two division passes.
// a failed read goes from accept straight to finish, a zero vector from prep to finish.
// synchronous reset clears the filter accumulator and all control state.
// the response sits in an output register; a stalled response holds the final step.
`default_nettype none

module magnet_angle_from_xy_field import maf_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   maf_req_if.sink   req_ch,
   maf_rsp_if.source rsp_ch
);

   state_type           state_ff, state_in;
   logic [FIELD_W-1:0]  x_ff, x_in;
   logic [FIELD_W-1:0]  y_ff, y_in;
   logic                err_ff, err_in;
   logic                x_neg_ff, x_neg_in;
   logic                y_neg_ff, y_neg_in;
   logic                swap_ff, swap_in;
   logic [OCT_W-1:0]    a_ff, a_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0]  angle_ff, angle_in;
   logic [ANGLE_W-1:0]  filt_ff, filt_in;
   logic                rerr_ff, rerr_in;

   div_ctl_type         div_ctl;
   div_sts_type         div_sts;
   logic [REM_W-1:0]    div_rem_init;
   logic [QUO_W-1:0]    div_low_init;
   logic [FIELD_W-1:0]  div_divisor;
   logic [QUO_W-1:0]    quotient;

   logic [FIELD_W-1:0]  ax, ay, mag_max, mag_min;
   logic [NUM_W-1:0]    num;
   logic [SCALED_W-1:0] scaled;
   logic [ANGLE_W-1:0]  a9, folded;
   logic [ACC_W-1:0]    acc_next;
   logic                commit;

   maf_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .rem_init (div_rem_init),
      .low_init (div_low_init),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (quotient)
   );

   // magnitudes; -2048 maps to 2048, which still fits unsigned
   assign ax      = x_ff[FIELD_W-1] ? (~x_ff + FIELD_W'(1)) : x_ff;
   assign ay      = y_ff[FIELD_W-1] ? (~y_ff + FIELD_W'(1)) : y_ff;
   assign mag_max = (ax > ay) ? ax : ay;
   assign mag_min = (ax > ay) ? ay : ax;
   assign num     = NUM_W'(mag_min) * NUM_W'(RATIO_SCALE);

   assign scaled = SCALED_W'(quotient) * SCALED_W'(OCTANT_DEG) + SCALED_W'(ROUND_BIAS);

   // quadrant folding
   assign a9 = ANGLE_W'(a_ff);
   always_comb begin
      case ({x_neg_ff, y_neg_ff})
         2'b00:   folded = a9;
         2'b10:   folded = ANGLE_W'(STRAIGHT_ANGLE) - a9;
         2'b11:   folded = ANGLE_W'(STRAIGHT_ANGLE) + a9;
         default: folded = ANGLE_W'(FULL_ANGLE) - a9;
      endcase
   end

   assign commit   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);
   assign acc_next = acc_ff - (acc_ff >> 2) + ACC_W'(folded);

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      err_in       = err_ff;
      x_neg_in     = x_neg_ff;
      y_neg_in     = y_neg_ff;
      swap_in      = swap_ff;
      a_in         = a_ff;
      acc_in       = acc_ff;
      angle_in     = angle_ff;
      filt_in      = filt_ff;
      rerr_in      = rerr_ff;
      div_ctl      = '0;
      div_rem_init = '0;
      div_low_init = '0;
      div_divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               x_in     = {req_ch.x_high_byte,
                           req_ch.low_nibbles_byte[BYTE_W-1:NIBBLE_W]};
               y_in     = {req_ch.y_high_byte,
                           req_ch.low_nibbles_byte[NIBBLE_W-1:0]};
               err_in   = ~req_ch.read_ok;
               state_in = req_ch.read_ok ? ST_PREP : ST_FINISH;
            end
         end
         ST_PREP: begin
            x_neg_in = x_ff[FIELD_W-1];
            y_neg_in = y_ff[FIELD_W-1];
            swap_in  = !(ax > ay);
            if (ax == '0 && ay == '0) begin
               a_in     = '0;
               state_in = ST_FINISH;
            end else begin
               div_ctl.start = 1'b1;
               div_ctl.steps = STEP_W'(RATIO_STEPS);
               div_rem_init  = REM_W'(num[NUM_W-1:QUO_W]);
               div_low_init  = num[QUO_W-1:0];
               div_divisor   = mag_max;
               state_in      = ST_DIV_RATIO;
            end
         end
         ST_DIV_RATIO: begin
            if (div_sts.done) begin
               div_ctl.start = 1'b1;
               div_ctl.steps = STEP_W'(SCALE_STEPS);
               div_rem_init  = REM_W'(scaled[SCALED_W-1:SCALE_STEPS]);
               div_low_init  = {scaled[SCALE_STEPS-1:0], {(QUO_W-SCALE_STEPS){1'b0}}};
               div_divisor   = FIELD_W'(RATIO_SCALE);
               state_in      = ST_DIV_SCALE;
            end
         end
         ST_DIV_SCALE: begin
            if (div_sts.done) begin
               a_in = swap_ff ? (OCT_W'(RIGHT_ANGLE) - OCT_W'(quotient[SCALE_STEPS-1:0]))
                              : OCT_W'(quotient[SCALE_STEPS-1:0]);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (commit) begin
               rerr_in = err_ff;
               if (err_ff) begin
                  angle_in = '0;
                  filt_in  = acc_ff[ACC_W-1:2];
               end else begin
                  angle_in = folded;
                  acc_in   = acc_next;
                  filt_in  = acc_next[ACC_W-1:2];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = commit | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      err_ff   <= err_in;
      x_neg_ff <= x_neg_in;
      y_neg_ff <= y_neg_in;
      swap_ff  <= swap_in;
      a_ff     <= a_in;
      angle_ff <= angle_in;
      filt_ff  <= filt_in;
      rerr_ff  <= rerr_in;
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.angle_deg      = angle_ff;
   assign rsp_ch.filtered_angle = filt_ff;
   assign rsp_ch.read_error     = rerr_ff;

   // divider is only kicked off from the prep and ratio steps
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> (state_ff == ST_PREP || state_ff == ST_DIV_RATIO))
      else $error("divider started outside its sequence");

   // no division left running once the angle is ready
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !div_sts.busy)
      else $error("divider busy at finish");

   // octant angle stays within a right angle
   a_oct_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !err_ff) |-> (a_ff <= OCT_W'(RIGHT_ANGLE)))
      else $error("octant angle out of range");

   // a failed read leaves the filter untouched
   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      (commit && err_ff) |=> (acc_ff == $past(acc_ff)))
      else $error("filter changed on read error");

endmodule

`default_nettype wire
